### hdl/array_linked_list_manager_assert.svh
// assertion helpers for the linked list manager, clocked on clock, held off in reset
`ifndef ARRAY_LINKED_LIST_MANAGER_ASSERT_SVH
`define ARRAY_LINKED_LIST_MANAGER_ASSERT_SVH

// consequence checked in the same cycle
`define ALM_CHECK(label, ante, cons, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error(msg);

// consequence checked in the cycle after the antecedent
`define ALM_CHECK_NEXT(label, ante, cons, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error(msg);

`endif

### hdl/alm_pkg.sv
package alm_pkg;

   localparam int CAPACITY_DEFAULT    = 256;
   localparam int VALUE_WIDTH_DEFAULT = 32;

   typedef enum logic {
      MODE_INSERT,
      MODE_DELETE
   } mode_type;

   typedef enum logic [1:0] {
      STATUS_OK,
      STATUS_UNUSED,
      STATUS_SENTINEL,
      STATUS_FULL
   } status_type;

   typedef struct packed {
      mode_type           mode;
      logic [7:0]         slot;
      logic signed [31:0] value_in;
   } req_type;

   typedef struct packed {
      status_type         status;
      logic [7:0]         new_slot;
      logic signed [31:0] value_out;
      logic [7:0]         head_slot;
      logic [7:0]         tail_slot;
      logic [7:0]         count;
   } rsp_type;

endpackage

### hdl/array_linked_list_manager.sv
// Circular doubly linked list kept in one row memory (in-use flag, next link, prev link and
// value per slot) with slot 0 as the sentinel and a free chain through the next links.
// After reset the block sweeps the memory once, one row per cycle, and takes no request until
// the sweep is done. A request that reports an error writes no row. After the reads, an insert
// or delete rewrites up to three rows, one per cycle, as the row memory has a single write port:
// the new or freed row, the row before, then the row after, skipped for an insert into the
// empty list or a delete of the only element. The next request is taken the cycle after the
// result is loaded into the output register, so a result can wait while the next one is being
// worked on. head_slot, tail_slot and count reflect the list after the request.
module array_linked_list_manager import alm_pkg::*; #(
   parameter int CAPACITY    = CAPACITY_DEFAULT,
   parameter int VALUE_WIDTH = VALUE_WIDTH_DEFAULT
) (
   input  logic    clock,
   input  logic    reset,
   input  logic    req_valid,
   output logic    req_stall,
   input  req_type req_data,
   output logic    rsp_valid,
   input  logic    rsp_stall,
   output rsp_type rsp_data
);

   `include "array_linked_list_manager_assert.svh"

   localparam int IDX_W = $clog2(CAPACITY);

   typedef struct packed {
      logic                   used;
      logic [IDX_W-1:0]       nxt;
      logic [IDX_W-1:0]       prv;
      logic [VALUE_WIDTH-1:0] val;
   } row_type;

   localparam int ROW_W = $bits(row_type);
   localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(CAPACITY - 1);

   typedef enum logic [2:0] {
      S_INIT,
      S_IDLE,
      S_CHECK,
      S_LINK,
      S_FIX,
      S_OUT
   } state_type;

   state_type state_ff, state_in;
   logic [IDX_W-1:0] init_idx_ff, init_idx_in;
   logic [IDX_W-1:0] free_head_ff, free_head_in;
   logic [IDX_W-1:0] count_ff, count_in;
   logic [IDX_W-1:0] head_ff, head_in;
   logic [IDX_W-1:0] tail_ff, tail_in;
   logic             rsp_valid_ff, rsp_valid_in;
   rsp_type          rsp_data_ff, rsp_data_in;

   mode_type                      mode_ff, mode_in;
   logic [IDX_W-1:0]              slot_ff, slot_in;
   logic                          slot_ok_ff, slot_ok_in;
   logic signed [VALUE_WIDTH-1:0] value_ff, value_in;
   row_type                       slot_row_ff, slot_row_in;
   logic [IDX_W-1:0]              link_a_ff, link_a_in;
   logic [IDX_W-1:0]              link_b_ff, link_b_in;
   status_type                    res_status_ff, res_status_in;
   logic [7:0]                    res_new_slot_ff, res_new_slot_in;
   logic signed [31:0]            res_value_ff, res_value_in;

   logic             wr_en;
   logic [IDX_W-1:0] wr_addr;
   row_type          wr_row;
   logic             rd_en;
   logic [IDX_W-1:0] rd_addr_a;
   logic [IDX_W-1:0] rd_addr_b;
   logic [ROW_W-1:0] rd_data_a;
   logic [ROW_W-1:0] rd_data_b;
   row_type          rd_row_a;
   row_type          rd_row_b;
   logic             slot_used;
   logic             out_free;

   logic             is_idle;
   logic             chain_empty;
   logic             list_full;
   logic             insert_start;

   alm_row_ram #(
      .DEPTH (CAPACITY),
      .WIDTH (ROW_W)
   ) u_row_ram (
      .clock     (clock),
      .wr_en     (wr_en),
      .wr_addr   (wr_addr),
      .wr_data   (wr_row),
      .rd_en     (rd_en),
      .rd_addr_a (rd_addr_a),
      .rd_addr_b (rd_addr_b),
      .rd_data_a (rd_data_a),
      .rd_data_b (rd_data_b)
   );

   assign rd_row_a  = rd_data_a;
   assign rd_row_b  = rd_data_b;
   assign slot_used = slot_ok_ff && rd_row_a.used;
   assign out_free  = !rsp_valid_ff || !rsp_stall;

   assign req_stall = (state_ff != S_IDLE);
   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_data_ff;

   always_comb begin
      state_in        = state_ff;
      init_idx_in     = init_idx_ff;
      free_head_in    = free_head_ff;
      count_in        = count_ff;
      head_in         = head_ff;
      tail_in         = tail_ff;
      rsp_valid_in    = rsp_valid_ff;
      rsp_data_in     = rsp_data_ff;
      mode_in         = mode_ff;
      slot_in         = slot_ff;
      slot_ok_in      = slot_ok_ff;
      value_in        = value_ff;
      slot_row_in     = slot_row_ff;
      link_a_in       = link_a_ff;
      link_b_in       = link_b_ff;
      res_status_in   = res_status_ff;
      res_new_slot_in = res_new_slot_ff;
      res_value_in    = res_value_ff;
      wr_en           = 1'b0;
      wr_addr         = '0;
      wr_row          = '0;
      rd_en           = 1'b0;
      rd_addr_a       = '0;
      rd_addr_b       = '0;

      if (rsp_valid_ff && !rsp_stall) begin
         rsp_valid_in = 1'b0;
      end

      unique case (state_ff)
         S_INIT: begin
            // build the empty list and the free chain 1 -> 2 -> ... -> last
            wr_en       = 1'b1;
            wr_addr     = init_idx_ff;
            wr_row.used = (init_idx_ff == '0);
            if (init_idx_ff == '0 || init_idx_ff == LAST_IDX) begin
               wr_row.nxt = '0;
            end else begin
               wr_row.nxt = init_idx_ff + 1'b1;
            end
            if (init_idx_ff == LAST_IDX) begin
               state_in = S_IDLE;
            end else begin
               init_idx_in = init_idx_ff + 1'b1;
            end
         end
         S_IDLE: begin
            if (req_valid) begin
               rd_en      = 1'b1;
               rd_addr_a  = IDX_W'(req_data.slot);
               rd_addr_b  = free_head_ff;
               mode_in    = req_data.mode;
               slot_in    = IDX_W'(req_data.slot);
               slot_ok_in = (32'(req_data.slot) < 32'(CAPACITY));
               value_in   = VALUE_WIDTH'(req_data.value_in);
               state_in   = S_CHECK;
            end
         end
         S_CHECK: begin
            res_status_in   = STATUS_OK;
            res_new_slot_in = '0;
            res_value_in    = '0;
            priority if (!slot_used) begin
               res_status_in = STATUS_UNUSED;
               state_in      = S_OUT;
            end else if (mode_ff == MODE_INSERT) begin
               if (free_head_ff == '0) begin
                  res_status_in = STATUS_FULL;
                  state_in      = S_OUT;
               end else begin
                  // new element takes the free head, linked between slot and its successor
                  wr_en           = 1'b1;
                  wr_addr         = free_head_ff;
                  wr_row.used     = 1'b1;
                  wr_row.nxt      = rd_row_a.nxt;
                  wr_row.prv      = slot_ff;
                  wr_row.val      = value_ff;
                  free_head_in    = rd_row_b.nxt;
                  count_in        = count_ff + 1'b1;
                  res_new_slot_in = 8'(free_head_ff);
                  slot_row_in     = rd_row_a;
                  link_a_in       = free_head_ff;
                  link_b_in       = rd_row_a.nxt;
                  rd_en           = 1'b1;
                  rd_addr_a       = rd_row_a.nxt;
                  state_in        = S_LINK;
               end
            end else if (slot_ff == '0) begin
               res_status_in = STATUS_SENTINEL;
               state_in      = S_OUT;
            end else begin
               // free the slot onto the front of the free chain, fetch its neighbors
               wr_en        = 1'b1;
               wr_addr      = slot_ff;
               wr_row.nxt   = free_head_ff;
               free_head_in = slot_ff;
               count_in     = count_ff - 1'b1;
               res_value_in = 32'(signed'(rd_row_a.val));
               link_a_in    = rd_row_a.prv;
               link_b_in    = rd_row_a.nxt;
               rd_en        = 1'b1;
               rd_addr_a    = rd_row_a.prv;
               rd_addr_b    = rd_row_a.nxt;
               state_in     = S_LINK;
            end
         end
         S_LINK: begin
            wr_en = 1'b1;
            if (mode_ff == MODE_INSERT) begin
               wr_addr    = slot_ff;
               wr_row     = slot_row_ff;
               wr_row.nxt = link_a_ff;
            end else begin
               wr_addr    = link_a_ff;
               wr_row     = rd_row_a;
               wr_row.nxt = link_b_ff;
            end
            // both neighbors on the same row: fix the back link here too
            if (wr_addr == link_b_ff) begin
               wr_row.prv = (mode_ff == MODE_INSERT) ? link_a_ff : link_b_ff;
               state_in   = S_OUT;
            end else begin
               state_in = S_FIX;
            end
         end
         S_FIX: begin
            wr_en      = 1'b1;
            wr_addr    = link_b_ff;
            wr_row     = (mode_ff == MODE_INSERT) ? rd_row_a : rd_row_b;
            wr_row.prv = link_a_ff;
            state_in   = S_OUT;
         end
         S_OUT: begin
            if (out_free) begin
               rsp_valid_in          = 1'b1;
               rsp_data_in.status    = res_status_ff;
               rsp_data_in.new_slot  = res_new_slot_ff;
               rsp_data_in.value_out = res_value_ff;
               rsp_data_in.head_slot = 8'(head_ff);
               rsp_data_in.tail_slot = 8'(tail_ff);
               rsp_data_in.count     = 8'(count_ff);
               state_in              = S_IDLE;
            end
         end
         default: begin
            state_in = S_INIT;
         end
      endcase

      // sentinel row holds head and tail, mirror it
      if (wr_en && wr_addr == '0) begin
         head_in = wr_row.nxt;
         tail_in = wr_row.prv;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_INIT;
         init_idx_ff  <= '0;
         free_head_ff <= IDX_W'(1);
         count_ff     <= '0;
         head_ff      <= '0;
         tail_ff      <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         init_idx_ff  <= init_idx_in;
         free_head_ff <= free_head_in;
         count_ff     <= count_in;
         head_ff      <= head_in;
         tail_ff      <= tail_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      rsp_data_ff     <= rsp_data_in;
      mode_ff         <= mode_in;
      slot_ff         <= slot_in;
      slot_ok_ff      <= slot_ok_in;
      value_ff        <= value_in;
      slot_row_ff     <= slot_row_in;
      link_a_ff       <= link_a_in;
      link_b_ff       <= link_b_in;
      res_status_ff   <= res_status_in;
      res_new_slot_ff <= res_new_slot_in;
      res_value_ff    <= res_value_in;
   end

   assign is_idle      = (state_ff == S_IDLE);
   assign chain_empty  = (free_head_ff == '0);
   assign list_full    = (count_ff == LAST_IDX);
   assign insert_start = (state_ff == S_CHECK) && (state_in == S_LINK) &&
                         (mode_ff == MODE_INSERT);

   `ALM_CHECK(a_free_chain_count, is_idle, chain_empty == list_full, "free chain vs count")
   `ALM_CHECK(a_empty_head_count, is_idle, (head_ff == '0) == (count_ff == '0), "head vs count")
   `ALM_CHECK_NEXT(a_insert_count, insert_start, count_ff == $past(count_ff) + 1'b1, "insert count")

endmodule

### hdl/alm_row_ram.sv
module alm_row_ram import alm_pkg::*; #(
   parameter int DEPTH = CAPACITY_DEFAULT,
   parameter int WIDTH = 1 + 2 * $clog2(CAPACITY_DEFAULT) + VALUE_WIDTH_DEFAULT
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic                     rd_en,
   input  logic [$clog2(DEPTH)-1:0] rd_addr_a,
   input  logic [$clog2(DEPTH)-1:0] rd_addr_b,
   output logic [WIDTH-1:0]         rd_data_a,
   output logic [WIDTH-1:0]         rd_data_b
);

   logic [WIDTH-1:0] mem [DEPTH];

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      // read data holds until the next read
      if (rd_en) begin
         rd_data_a <= mem[rd_addr_a];
         rd_data_b <= mem[rd_addr_b];
      end
   end

endmodule

### sim/tb_array_linked_list_manager.sv
`timescale 1ns / 1ps

module tb_array_linked_list_manager;
   import alm_pkg::*;

   localparam int RANDOM_REQUESTS = 1030;
   localparam int PHASE_LENGTH    = 350;

   class list_scoreboard;
      logic [7:0]         fwd_link [CAPACITY_DEFAULT];
      logic [7:0]         back_link [CAPACITY_DEFAULT];
      bit                 occupied [CAPACITY_DEFAULT];
      logic signed [31:0] payload [CAPACITY_DEFAULT];
      logic [7:0]         free_top;
      logic [7:0]         list_length;
      rsp_type            pending [$];
      int                 error_count;

      function new();
         for (int idx = 0; idx < CAPACITY_DEFAULT; idx++) begin
            fwd_link[idx]  = 8'(idx + 1);
            back_link[idx] = '0;
            occupied[idx]  = 1'b0;
            payload[idx]   = '0;
         end
         fwd_link[0]                  = '0;
         fwd_link[CAPACITY_DEFAULT-1] = '0;
         occupied[0]                  = 1'b1;
         free_top                     = 8'd1;
         list_length                  = '0;
         error_count                  = 0;
      endfunction

      // k-th occupied slot, the sentinel counting as the zeroth
      function logic [7:0] pick_used_slot(bit allow_sentinel);
         int k;
         int seen;
         k = $urandom_range(allow_sentinel ? 0 : 1, list_length);
         seen = 0;
         for (int idx = 0; idx < CAPACITY_DEFAULT; idx++) begin
            if (occupied[idx]) begin
               if (seen == k) return 8'(idx);
               seen++;
            end
         end
         return '0;
      endfunction

      function void note_request(req_type r);
         rsp_type    want;
         logic [7:0] pos;
         logic [7:0] after;
         logic [7:0] p;
         logic [7:0] n;
         want = '0;
         want.status = STATUS_OK;
         if (!occupied[r.slot]) begin
            want.status = STATUS_UNUSED;
         end else if (r.mode == MODE_INSERT) begin
            if (free_top == 0) begin
               want.status = STATUS_FULL;
            end else begin
               pos = free_top;
               free_top = fwd_link[pos];
               payload[pos] = r.value_in;
               after = fwd_link[r.slot];
               fwd_link[pos] = after;
               back_link[pos] = r.slot;
               fwd_link[r.slot] = pos;
               back_link[after] = pos;
               occupied[pos] = 1'b1;
               list_length++;
               want.new_slot = pos;
            end
         end else if (r.slot == 0) begin
            want.status = STATUS_SENTINEL;
         end else begin
            p = back_link[r.slot];
            n = fwd_link[r.slot];
            fwd_link[p] = n;
            back_link[n] = p;
            want.value_out = payload[r.slot];
            payload[r.slot] = '0;
            back_link[r.slot] = '0;
            occupied[r.slot] = 1'b0;
            // freed slot goes on the front of the free chain
            fwd_link[r.slot] = free_top;
            free_top = r.slot;
            list_length--;
         end
         want.head_slot = fwd_link[0];
         want.tail_slot = back_link[0];
         want.count     = list_length;
         pending.push_back(want);
      endfunction

      task report_mismatch(string msg);
         $display("mismatch at %0t: %s", $time, msg);
         error_count++;
      endtask

      task check_response(rsp_type got);
         rsp_type want;
         if (pending.size() == 0) begin
            report_mismatch($sformatf("response with no request outstanding: %p", got));
            return;
         end
         want = pending.pop_front();
         if (got.status !== want.status)
            report_mismatch($sformatf("status %0d, expected %0d", got.status, want.status));
         if (got.new_slot !== want.new_slot)
            report_mismatch($sformatf("new_slot %0d, expected %0d", got.new_slot,
                                      want.new_slot));
         if (got.value_out !== want.value_out)
            report_mismatch($sformatf("value_out %0d, expected %0d", got.value_out,
                                      want.value_out));
         if (got.head_slot !== want.head_slot)
            report_mismatch($sformatf("head_slot %0d, expected %0d", got.head_slot,
                                      want.head_slot));
         if (got.tail_slot !== want.tail_slot)
            report_mismatch($sformatf("tail_slot %0d, expected %0d", got.tail_slot,
                                      want.tail_slot));
         if (got.count !== want.count)
            report_mismatch($sformatf("count %0d, expected %0d", got.count, want.count));
      endtask
   endclass

   logic    clock     = 1'b0;
   logic    reset     = 1'b1;
   logic    req_valid = 1'b0;
   logic    req_stall;
   req_type req_data  = '0;
   logic    rsp_valid;
   logic    rsp_stall = 1'b0;
   rsp_type rsp_data;

   int send_idle_pct = 21;
   int recv_idle_pct = 82;
   bit filling       = 1'b1;

   list_scoreboard lists = new();

   array_linked_list_manager dut (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .req_data  (req_data),
      .rsp_valid (rsp_valid),
      .rsp_stall (rsp_stall),
      .rsp_data  (rsp_data)
   );

   always begin
      #10 clock = 1'b1;
      #10 clock = 1'b0;
   end

   always @(posedge clock) begin
      if (reset) begin
         rsp_stall <= 1'b0;
      end else begin
         rsp_stall <= ($urandom_range(0, 99) < recv_idle_pct);
      end
   end

   always @(posedge clock) begin
      if (!reset && rsp_valid && !rsp_stall) begin
         lists.check_response(rsp_data);
      end
   end

   // called at a rising edge, returns at the edge where the request is taken
   task automatic send_request(mode_type m, logic [7:0] s, logic signed [31:0] v);
      req_type r;
      r.mode     = m;
      r.slot     = s;
      r.value_in = v;
      if ($urandom_range(0, 99) < send_idle_pct) begin
         req_valid <= 1'b0;
         @(posedge clock);
         while ($urandom_range(0, 99) < send_idle_pct) @(posedge clock);
      end
      req_valid <= 1'b1;
      req_data  <= r;
      do @(posedge clock); while (req_stall);
      lists.note_request(r);
   endtask

   task automatic drain_responses();
      req_valid <= 1'b0;
      @(posedge clock);
      while (lists.pending.size() != 0) @(posedge clock);
   endtask

   initial begin
      int                 i;
      mode_type           m;
      logic [7:0]         s;
      logic signed [31:0] v;

      repeat (9) @(posedge clock);
      reset <= 1'b0;

      // empty list: sentinel delete and unused slots
      send_request(MODE_DELETE, 8'd0, 32'sd12345);
      send_request(MODE_DELETE, 8'd255, 32'sh7fff_ffff);
      send_request(MODE_INSERT, 8'd200, -32'sd1);
      // build a short list, inserting at the tail, the head and the middle
      send_request(MODE_INSERT, 8'd0, 32'sh7fff_ffff);
      send_request(MODE_INSERT, 8'd1, 32'sh8000_0000);
      send_request(MODE_INSERT, 8'd0, -32'sd1);
      send_request(MODE_INSERT, 8'd3, 32'sd0);
      send_request(MODE_INSERT, 8'd128, 32'sd7);
      // delete middle, tail, head and then the only element
      send_request(MODE_DELETE, 8'd4, 32'sd0);
      send_request(MODE_DELETE, 8'd2, -32'sd1);
      send_request(MODE_DELETE, 8'd3, 32'sh5555_5555);
      send_request(MODE_DELETE, 8'd1, 32'shaaaa_aaaa);
      send_request(MODE_DELETE, 8'd1, 32'sd0);
      // reuse of freed slots from the front of the free chain
      send_request(MODE_INSERT, 8'd0, 32'sh5555_5555);
      send_request(MODE_INSERT, 8'd1, 32'shaaaa_aaaa);
      send_request(MODE_INSERT, 8'd1, 32'sh8000_0000);
      send_request(MODE_DELETE, 8'd0, -32'sd1);
      send_request(MODE_INSERT, 8'd127, 32'sd1);

      for (i = 0; i < RANDOM_REQUESTS; i++) begin
         if (i == PHASE_LENGTH) begin
            drain_responses();
            send_idle_pct = 82;
            recv_idle_pct = 21;
         end else if (i == 2 * PHASE_LENGTH) begin
            drain_responses();
            send_idle_pct = 0;
            recv_idle_pct = 0;
         end
         // grow the list until the free chain runs dry, then shrink it to empty
         if (filling && lists.free_top == 0 && $urandom_range(0, 3) == 0) begin
            filling = 1'b0;
         end else if (!filling && lists.list_length == 0) begin
            filling = 1'b1;
         end
         m = (($urandom_range(0, 99) < 92) == filling) ? MODE_INSERT : MODE_DELETE;
         if ($urandom_range(0, 99) < 12) begin
            s = 8'($urandom_range(0, 255));
         end else if (m == MODE_INSERT) begin
            s = lists.pick_used_slot(1'b1);
         end else begin
            s = lists.pick_used_slot(lists.list_length == 0 || $urandom_range(0, 19) == 0);
         end
         case ($urandom_range(0, 15))
            0:       v = 32'sh7fff_ffff;
            1:       v = 32'sh8000_0000;
            2:       v = -32'sd1;
            3:       v = 32'sd0;
            default: v = $urandom;
         endcase
         send_request(m, s, v);
      end

      req_valid <= 1'b0;
      while (lists.pending.size() != 0) @(posedge clock);
      repeat (10) @(posedge clock);
      if (lists.error_count == 0) begin
         $display("[array_linked_list_manager] OK");
      end else begin
         $display("[array_linked_list_manager] ERROR");
      end
      $finish;
   end

   initial begin
      #10ms;
      $display("[array_linked_list_manager] ERROR");
      $finish;
   end

endmodule
